// ===== rtl/crm_pkg.sv =====
package crm_pkg;

   localparam int MAX_COLS_DEF   = 256;
   localparam int MAX_ROWS_DEF   = 256;
   localparam int MAX_KERNEL_DEF = 9;

   localparam int Q_SHIFT = 7;
   localparam int PROD_W  = 16;
   localparam int PIX_W   = 7;

   localparam logic CMD_COEF  = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   localparam logic [2:0] REG_IMAGE_COLS  = 3'd0;
   localparam logic [2:0] REG_IMAGE_ROWS  = 3'd1;
   localparam logic [2:0] REG_KERNEL_ROWS = 3'd2;
   localparam logic [2:0] REG_KERNEL_COLS = 3'd3;

   localparam logic [8:0] RST_IMAGE_COLS  = 9'd256;
   localparam logic [8:0] RST_IMAGE_ROWS  = 9'd256;
   localparam logic [3:0] RST_KERNEL_ROWS = 4'd3;
   localparam logic [3:0] RST_KERNEL_COLS = 4'd3;

   typedef enum logic [1:0] {
      ST_RUN   = 2'b01,
      ST_SWEEP = 2'b10
   } crm_state_type;

endpackage

// ===== rtl/crm_mac.sv =====
module crm_mac #(
   parameter int MAX_KERNEL = crm_pkg::MAX_KERNEL_DEF,
   parameter int SUM_W      = crm_pkg::PROD_W + $clog2(MAX_KERNEL * MAX_KERNEL + 1)
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic [crm_pkg::PIX_W-1:0] win [MAX_KERNEL][MAX_KERNEL],
   input  logic signed [7:0]       coef [MAX_KERNEL][MAX_KERNEL],
   input  logic                    tap_en [MAX_KERNEL][MAX_KERNEL],
   output logic signed [SUM_W-1:0] sum
);

   localparam int PW    = crm_pkg::PROD_W;
   localparam int ROW_W = PW + $clog2(MAX_KERNEL + 1);

   logic signed [PW-1:0]    prod_in  [MAX_KERNEL][MAX_KERNEL];
   logic signed [PW-1:0]    prod_ff  [MAX_KERNEL][MAX_KERNEL];
   logic signed [ROW_W-1:0] row_in   [MAX_KERNEL];
   logic signed [ROW_W-1:0] row_ff   [MAX_KERNEL];
   logic signed [SUM_W-1:0] sum_in;
   logic signed [SUM_W-1:0] sum_ff;

   always_comb begin
      for (int p = 0; p < MAX_KERNEL; p++) begin
         for (int q = 0; q < MAX_KERNEL; q++) begin
            prod_in[p][q] = coef[p][q] * $signed({1'b0, win[p][q]});
            prod_in[p][q] = tap_en[p][q] ? (prod_in[p][q] <<< 1) : '0;
         end
      end
   end

   always_comb begin
      for (int p = 0; p < MAX_KERNEL; p++) begin
         row_in[p] = '0;
         for (int q = 0; q < MAX_KERNEL; q++) begin
            row_in[p] = row_in[p] + ROW_W'(prod_ff[p][q]);
         end
      end
      sum_in = '0;
      for (int p = 0; p < MAX_KERNEL; p++) begin
         sum_in = sum_in + SUM_W'(row_ff[p]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         row_ff  <= row_in;
         sum_ff  <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

// ===== rtl/conv2d_relu_maxpool.sv =====
// Pixel words: one accepted per cycle while req_stall is low; a result passes stage 1,
// stages 2..5 and the output register to rsp. Coefficient words give no result.
// A write to either kernel size register starts a coefficient remap, one coefficient
// memory read per cycle; req_stall is high during the remap.
// Reset (synchronous) restores register defaults and clears counters and valids;
// line, coefficient and pooling memories hold no value until written.
module conv2d_relu_maxpool #(
   parameter int MAX_COLS   = crm_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS   = crm_pkg::MAX_ROWS_DEF,
   parameter int MAX_KERNEL = crm_pkg::MAX_KERNEL_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_cmd,
   input  logic [6:0]        req_coef_index,
   input  logic signed [7:0] req_coef_value,
   input  logic [7:0]        req_pixel,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_pooled_value,
   output logic [6:0]        rsp_pool_row,
   output logic [6:0]        rsp_pool_col,
   output logic              rsp_frame_last,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [8:0]        csr_data
);

   localparam int LINES      = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
   localparam int LW         = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int TAPS       = MAX_KERNEL * MAX_KERNEL;
   localparam int TW         = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int CW         = $clog2(MAX_COLS);
   localparam int RW         = $clog2(MAX_ROWS);
   localparam int CE_W       = $clog2(MAX_COLS + 1);
   localparam int RE_W       = $clog2(MAX_ROWS + 1);
   localparam int KE_W       = $clog2(MAX_KERNEL + 1);
   localparam int POOL_SLOTS = (MAX_COLS + 1) / 2;
   localparam int SW         = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
   localparam int PXW        = crm_pkg::PIX_W;
   localparam int SUM_W      = crm_pkg::PROD_W + $clog2(TAPS + 1);

   typedef struct packed {
      logic          conv;
      logic          fc_odd;
      logic          fr_odd;
      logic          emit;
      logic          last;
      logic [SW-1:0] slot;
      logic [6:0]    out_row;
      logic [6:0]    out_col;
   } meta_type;

   // configuration
   logic [8:0] cols_cfg_ff, rows_cfg_ff;
   logic [3:0] krows_cfg_ff, kcols_cfg_ff;
   logic [CE_W-1:0] cols_eff;
   logic [RE_W-1:0] rows_eff;
   logic [KE_W-1:0] kr_eff, kc_eff;
   logic csr_wr, kern_wr;

   // handshake and control
   logic en, req_acc, pix_acc, coef_acc;
   crm_pkg::crm_state_type state_ff, state_in;
   logic [TW-1:0] sweep_k_ff, sweep_k_d_ff;
   logic sweep_wr_ff;

   // counters
   logic [CW-1:0] c_ff, c_in;
   logic [RW-1:0] r_ff, r_in;
   logic [LW-1:0] line_ff, line_in;

   // stage 1
   logic s1_valid_ff;
   logic [PXW-1:0] s1_pix_ff;
   logic [CW-1:0] s1_c_ff;
   logic [RW-1:0] s1_r_ff;
   logic [LW-1:0] s1_line_ff;
   logic [PXW-1:0] line_rd_ff [LINES];
   logic [PXW-1:0] new_col [MAX_KERNEL];
   meta_type meta_in;

   // window and taps
   logic [PXW-1:0] win_ff [MAX_KERNEL][MAX_KERNEL];
   logic [TW-1:0] tap_idx_ff [MAX_KERNEL][MAX_KERNEL];
   logic tap_en_ff [MAX_KERNEL][MAX_KERNEL];
   logic signed [7:0] coef_tap_ff [MAX_KERNEL][MAX_KERNEL];
   logic signed [7:0] coef_mem [TAPS];
   logic signed [7:0] coef_rd_ff;

   // stages 2..5
   logic valid_ff [4];
   meta_type meta_ff [4];
   logic signed [SUM_W-1:0] sum;
   logic [7:0] pool_mem [POOL_SLOTS];
   logic [7:0] pool_rd_ff;
   logic [7:0] pool_left_ff;
   logic [7:0] val, m_pair, m_out;

   // output register
   logic rsp_valid_ff;
   logic [7:0] out_val_ff;
   logic [6:0] out_row_ff, out_col_ff;
   logic out_last_ff;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign kern_wr   = csr_wr && (csr_index == crm_pkg::REG_KERNEL_ROWS ||
                                 csr_index == crm_pkg::REG_KERNEL_COLS);

   always_comb begin
      int ci, ri, kri, kci;
      ci  = (cols_cfg_ff == '0) ? 1 :
            ((int'(cols_cfg_ff) > MAX_COLS) ? MAX_COLS : int'(cols_cfg_ff));
      ri  = (rows_cfg_ff == '0) ? 1 :
            ((int'(rows_cfg_ff) > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg_ff));
      kri = (krows_cfg_ff == '0) ? 1 :
            ((int'(krows_cfg_ff) > MAX_KERNEL) ? MAX_KERNEL : int'(krows_cfg_ff));
      kci = (kcols_cfg_ff == '0) ? 1 :
            ((int'(kcols_cfg_ff) > MAX_KERNEL) ? MAX_KERNEL : int'(kcols_cfg_ff));
      cols_eff = CE_W'(ci);
      rows_eff = RE_W'(ri);
      kr_eff   = KE_W'(kri);
      kc_eff   = KE_W'(kci);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_cfg_ff  <= crm_pkg::RST_IMAGE_COLS;
         rows_cfg_ff  <= crm_pkg::RST_IMAGE_ROWS;
         krows_cfg_ff <= crm_pkg::RST_KERNEL_ROWS;
         kcols_cfg_ff <= crm_pkg::RST_KERNEL_COLS;
      end else if (csr_wr) begin
         case (csr_index)
            crm_pkg::REG_IMAGE_COLS:  cols_cfg_ff  <= csr_data;
            crm_pkg::REG_IMAGE_ROWS:  rows_cfg_ff  <= csr_data;
            crm_pkg::REG_KERNEL_ROWS: krows_cfg_ff <= csr_data[3:0];
            crm_pkg::REG_KERNEL_COLS: kcols_cfg_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en || state_ff != crm_pkg::ST_RUN || sweep_wr_ff;
   assign req_acc   = req_valid && !req_stall;
   assign pix_acc   = req_acc && req_cmd == crm_pkg::CMD_PIXEL;
   assign coef_acc  = req_acc && req_cmd == crm_pkg::CMD_COEF;

   // coefficient remap after a kernel size change
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         crm_pkg::ST_RUN:   if (kern_wr) state_in = crm_pkg::ST_SWEEP;
         crm_pkg::ST_SWEEP: if (int'(sweep_k_ff) == TAPS - 1) state_in = crm_pkg::ST_RUN;
         default:           state_in = crm_pkg::ST_RUN;
      endcase
      if (kern_wr) state_in = crm_pkg::ST_SWEEP;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= crm_pkg::ST_RUN;
         sweep_k_ff  <= '0;
         sweep_wr_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         sweep_wr_ff <= state_ff == crm_pkg::ST_SWEEP && !kern_wr;
         if (kern_wr || state_ff != crm_pkg::ST_SWEEP) begin
            sweep_k_ff <= '0;
         end else begin
            sweep_k_ff <= sweep_k_ff + TW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (coef_acc && int'(req_coef_index) < TAPS) begin
         coef_mem[TW'(req_coef_index)] <= req_coef_value;
      end
      coef_rd_ff   <= coef_mem[sweep_k_ff];
      sweep_k_d_ff <= sweep_k_ff;
   end

   always_ff @(posedge clock) begin
      for (int p = 0; p < MAX_KERNEL; p++) begin
         for (int q = 0; q < MAX_KERNEL; q++) begin
            tap_idx_ff[p][q] <= TW'((p - MAX_KERNEL + int'(kr_eff)) * int'(kc_eff) +
                                    (q - MAX_KERNEL + int'(kc_eff)));
            tap_en_ff[p][q]  <= p >= MAX_KERNEL - int'(kr_eff) &&
                                q >= MAX_KERNEL - int'(kc_eff);
            if (coef_acc && tap_en_ff[p][q] &&
                int'(tap_idx_ff[p][q]) == int'(req_coef_index)) begin
               coef_tap_ff[p][q] <= req_coef_value;
            end else if (sweep_wr_ff && tap_en_ff[p][q] &&
                         tap_idx_ff[p][q] == sweep_k_d_ff) begin
               coef_tap_ff[p][q] <= coef_rd_ff;
            end
         end
      end
   end

   // position counters
   always_comb begin
      c_in    = c_ff;
      r_in    = r_ff;
      line_in = line_ff;
      if (int'(c_ff) + 1 >= int'(cols_eff)) begin
         c_in = '0;
         if (int'(r_ff) + 1 >= int'(rows_eff)) begin
            r_in    = '0;
            line_in = '0;
         end else begin
            r_in    = r_ff + RW'(1);
            line_in = (int'(line_ff) + 1 >= LINES) ? '0 : line_ff + LW'(1);
         end
      end else begin
         c_in = c_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_wr) begin
         c_ff    <= '0;
         r_ff    <= '0;
         line_ff <= '0;
      end else if (pix_acc) begin
         c_ff    <= c_in;
         r_ff    <= r_in;
         line_ff <= line_in;
      end
   end

   // line buffers, one memory per stored row
   for (genvar l = 0; l < LINES; l++) begin : g_line
      logic [PXW-1:0] line_mem [MAX_COLS];
      always_ff @(posedge clock) begin
         if (pix_acc) begin
            line_rd_ff[l] <= line_mem[c_ff];
            if (int'(line_ff) == l) begin
               line_mem[c_ff] <= req_pixel[7:1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= pix_acc;
      end
      if (pix_acc) begin
         s1_pix_ff  <= req_pixel[7:1];
         s1_c_ff    <= c_ff;
         s1_r_ff    <= r_ff;
         s1_line_ff <= line_ff;
      end
   end

   // stage 1: new window column and pooling position
   always_comb begin
      int d, sel;
      for (int p = 0; p < MAX_KERNEL; p++) begin
         d   = MAX_KERNEL - 1 - p;
         sel = (int'(s1_line_ff) >= d) ? int'(s1_line_ff) - d :
               int'(s1_line_ff) + LINES - d;
         if (p == MAX_KERNEL - 1) begin
            new_col[p] = s1_pix_ff;
         end else begin
            new_col[p] = line_rd_ff[LW'(sel)];
         end
      end
   end

   always_comb begin
      int fr, fc, prow, pcol;
      fr   = int'(s1_r_ff) + 1 - int'(kr_eff);
      fc   = int'(s1_c_ff) + 1 - int'(kc_eff);
      prow = (int'(rows_eff) - int'(kr_eff) + 1) >>> 1;
      pcol = (int'(cols_eff) - int'(kc_eff) + 1) >>> 1;
      meta_in.conv    = fr >= 0 && fc >= 0;
      meta_in.fc_odd  = fc[0];
      meta_in.fr_odd  = fr[0];
      meta_in.emit    = meta_in.conv && fc[0] && fr[0] &&
                        (fr >>> 1) < prow && (fc >>> 1) < pcol;
      meta_in.last    = (fr >>> 1) + 1 == prow && (fc >>> 1) + 1 == pcol;
      meta_in.slot    = SW'(fc >>> 1);
      meta_in.out_row = 7'(fr >>> 1);
      meta_in.out_col = 7'(fc >>> 1);
   end

   always_ff @(posedge clock) begin
      if (en && s1_valid_ff) begin
         for (int p = 0; p < MAX_KERNEL; p++) begin
            for (int q = 0; q < MAX_KERNEL - 1; q++) begin
               win_ff[p][q] <= win_ff[p][q + 1];
            end
            win_ff[p][MAX_KERNEL - 1] <= new_col[p];
         end
      end
   end

   crm_mac #(
      .MAX_KERNEL (MAX_KERNEL),
      .SUM_W      (SUM_W)
   ) u_mac (
      .clock  (clock),
      .en     (en),
      .win    (win_ff),
      .coef   (coef_tap_ff),
      .tap_en (tap_en_ff),
      .sum    (sum)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 4; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= s1_valid_ff;
         for (int s = 1; s < 4; s++) begin
            valid_ff[s] <= valid_ff[s - 1];
         end
      end
      if (en) begin
         meta_ff[0] <= meta_in;
         for (int s = 1; s < 4; s++) begin
            meta_ff[s] <= meta_ff[s - 1];
         end
      end
   end

   // rectify, scale, saturate, pool
   always_comb begin
      logic signed [SUM_W-1:0] sh;
      sh = sum >>> crm_pkg::Q_SHIFT;
      if (sum < 0) begin
         val = '0;
      end else if (sh > SUM_W'(255)) begin
         val = 8'd255;
      end else begin
         val = sh[7:0];
      end
      m_pair = (pool_left_ff > val) ? pool_left_ff : val;
      m_out  = (pool_rd_ff > m_pair) ? pool_rd_ff : m_pair;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pool_rd_ff <= pool_mem[meta_ff[2].slot];
         if (valid_ff[3] && meta_ff[3].conv && meta_ff[3].fc_odd && !meta_ff[3].fr_odd) begin
            pool_mem[meta_ff[3].slot] <= m_pair;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         if (valid_ff[3] && meta_ff[3].conv && !meta_ff[3].fc_odd) begin
            pool_left_ff <= val;
         end
         rsp_valid_ff <= valid_ff[3] && meta_ff[3].emit;
      end
      if (en) begin
         out_val_ff  <= m_out;
         out_row_ff  <= meta_ff[3].out_row;
         out_col_ff  <= meta_ff[3].out_col;
         out_last_ff <= meta_ff[3].last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pooled_value = out_val_ff;
   assign rsp_pool_row     = out_row_ff;
   assign rsp_pool_col     = out_col_ff;
   assign rsp_frame_last   = out_last_ff;

endmodule

// ===== sim/crm_checker.sv =====
module crm_checker
   import crm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic              req_cmd,
   input  logic [6:0]        req_coef_index,
   input  logic signed [7:0] req_coef_value,
   input  logic [7:0]        req_pixel,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [7:0]        rsp_pooled_value,
   input  logic [6:0]        rsp_pool_row,
   input  logic [6:0]        rsp_pool_col,
   input  logic              rsp_frame_last,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [8:0]        csr_data,
   output int                pending,
   output int                errors
);

   localparam int KMAX  = MAX_KERNEL_DEF;
   localparam int LINES = (KMAX > 1) ? KMAX - 1 : 1;
   localparam int COLS  = MAX_COLS_DEF;
   localparam int TAPS  = KMAX * KMAX;

   typedef struct packed {
      logic [7:0] value;
      logic [6:0] row;
      logic [6:0] col;
      logic       last;
   } pool_word_t;

   pool_word_t        pool_q[$];
   logic [8:0]        cfg_cols, cfg_rows;
   logic [3:0]        cfg_kr, cfg_kc;
   logic [6:0]        line_mem[0:COLS*LINES-1];
   logic signed [7:0] coef_mem[0:TAPS-1];
   logic [6:0]        win[0:TAPS-1];
   logic [7:0]        pool_row_mem[0:COLS/2];
   logic [7:0]        pool_left;
   int                col_cnt, row_cnt;

   function automatic int clamp_cfg(int v, int hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   task automatic filter_pixel(input logic [7:0] pix);
      int cols, rows, kr, kc, r, c, src, sum, t, fr, fc, val, m, slot, prow, pcol;
      logic [6:0] half, v;
      pool_word_t w;
      cols = clamp_cfg(cfg_cols, MAX_COLS_DEF);
      rows = clamp_cfg(cfg_rows, MAX_ROWS_DEF);
      kr   = clamp_cfg(cfg_kr, KMAX);
      kc   = clamp_cfg(cfg_kc, KMAX);
      r    = row_cnt;
      c    = col_cnt;
      if (c >= cols) c = cols - 1;
      half = pix >> 1;
      for (int i = 0; i < kr; i++) begin
         for (int j = 0; j + 1 < kc; j++) win[i*KMAX+j] = win[i*KMAX+j+1];
         if (i + 1 == kr) begin
            v = half;
         end else begin
            src = r + LINES * 16 - (kr - 1) + i;
            v = line_mem[(src % LINES) * COLS + c];
         end
         win[i*KMAX+kc-1] = v;
      end
      if (kr > 1) line_mem[(r % LINES) * COLS + c] = half;
      if (r + 1 >= kr && c + 1 >= kc) begin
         sum = 0;
         fr = r + 1 - kr;
         fc = c + 1 - kc;
         prow = (rows - kr + 1) / 2;
         pcol = (cols - kc + 1) / 2;
         for (int i = 0; i < kr; i++)
            for (int j = 0; j < kc; j++) begin
               t = coef_mem[i*kc+j];
               sum += t * int'(win[i*KMAX+j]) * 2;
            end
         if (sum < 0) sum = 0;
         val = sum >>> Q_SHIFT;
         if (val > 255) val = 255;
         if (fc % 2 == 0) begin
            pool_left = val;
         end else begin
            m = (pool_left > val) ? pool_left : val;
            slot = fc >> 1;
            if (fr % 2 == 0) begin
               pool_row_mem[slot] = m;
            end else if ((fr >> 1) < prow && slot < pcol) begin
               if (pool_row_mem[slot] > m) m = pool_row_mem[slot];
               w.value = m;
               w.row   = fr >> 1;
               w.col   = slot;
               w.last  = ((fr >> 1) + 1 == prow && slot + 1 == pcol);
               pool_q.push_back(w);
            end
         end
      end
      if (c + 1 >= cols) begin
         col_cnt = 0;
         row_cnt = (r + 1 >= rows) ? 0 : r + 1;
      end else begin
         col_cnt = c + 1;
      end
   endtask

   initial begin
      pending = 0;
      errors  = 0;
   end

   always @(posedge clock) begin
      pool_word_t w;
      if (reset) begin
         cfg_cols  = RST_IMAGE_COLS;
         cfg_rows  = RST_IMAGE_ROWS;
         cfg_kr    = RST_KERNEL_ROWS;
         cfg_kc    = RST_KERNEL_COLS;
         col_cnt   = 0;
         row_cnt   = 0;
         pool_left = '0;
         pool_q.delete();
      end else begin
         if (csr_valid && csr_ready && csr_index <= REG_KERNEL_COLS) begin
            case (csr_index)
               REG_IMAGE_COLS:  cfg_cols = csr_data;
               REG_IMAGE_ROWS:  cfg_rows = csr_data;
               REG_KERNEL_ROWS: cfg_kr   = csr_data[3:0];
               default:         cfg_kc   = csr_data[3:0];
            endcase
            col_cnt = 0;
            row_cnt = 0;
         end
         if (req_valid && !req_stall) begin
            if (req_cmd == CMD_PIXEL) filter_pixel(req_pixel);
            else if (req_coef_index < TAPS) coef_mem[req_coef_index] = req_coef_value;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pool_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected word: value %0d row %0d col %0d last %0b",
                           rsp_pooled_value, rsp_pool_row, rsp_pool_col, rsp_frame_last);
            end else begin
               w = pool_q.pop_front();
               if (w.value !== rsp_pooled_value || w.row !== rsp_pool_row ||
                   w.col !== rsp_pool_col || w.last !== rsp_frame_last) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                              w.value, w.row, w.col, w.last, rsp_pooled_value,
                              rsp_pool_row, rsp_pool_col, rsp_frame_last);
               end
            end
         end
      end
      pending = pool_q.size();
   end

endmodule

// ===== sim/tb_conv2d_relu_maxpool.sv =====
module tb_conv2d_relu_maxpool;
   import crm_pkg::*;

   localparam logic [2:0] REG_SPARE = 3'd7;
   localparam int LIMIT = 400000;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_stall;
   logic              req_cmd = CMD_COEF;
   logic [6:0]        req_coef_index = '0;
   logic signed [7:0] req_coef_value = '0;
   logic [7:0]        req_pixel = '0;
   logic              rsp_valid;
   logic              rsp_stall = 0;
   logic [7:0]        rsp_pooled_value;
   logic [6:0]        rsp_pool_row;
   logic [6:0]        rsp_pool_col;
   logic              rsp_frame_last;
   logic              csr_valid = 0;
   logic              csr_ready;
   logic [2:0]        csr_index = '0;
   logic [8:0]        csr_data = '0;
   int                pending, errors;
   int                cycles = 0;
   int                stall_hold = 0;
   int                sent = 0;
   bit                calm = 0;
   bit                hold_req = 0;
   bit                hold_taken = 0;

   conv2d_relu_maxpool dut (.*);
   crm_checker checker_i (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb_conv2d_relu_maxpool: done, errors");
         $finish;
      end
   end

   // result side: random stalls, one long hold-off
   always @(posedge clock) begin
      if (hold_req && !hold_taken) begin
         hold_taken <= 1;
         stall_hold <= 400;
         rsp_stall  <= 1;
      end else if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
         rsp_stall  <= 1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 14);
      end
   end

   task automatic put_word(input logic cmd, input logic [6:0] idx,
                           input logic [7:0] val, input logic [7:0] pix);
      while (!calm && $urandom_range(99) < 14) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid      <= 1;
      req_cmd        <= cmd;
      req_coef_index <= idx;
      req_coef_value <= val;
      req_pixel      <= pix;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic settle();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [8:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // mode 0 random, 1 all max, 2 all min
   task automatic load_coefs(input int mode);
      logic [7:0] v;
      for (int k = 0; k < 81; k++) begin
         v = (mode == 1) ? 8'h7f : (mode == 2) ? 8'h80 : 8'($urandom_range(255));
         put_word(CMD_COEF, 7'(k), v, 8'($urandom_range(255)));
      end
      put_word(CMD_COEF, 7'd81, 8'($urandom_range(255)), 8'h00);
      put_word(CMD_COEF, 7'd127, 8'($urandom_range(255)), 8'hff);
   endtask

   // pix_mode 0 random, 1 bright, 2 extremes
   task automatic run_phase(input int cw, input int rw, input int krw, input int kcw,
                            input int frames, input int extra, input int pix_mode);
      int cols, rows;
      logic [7:0] p;
      settle();
      csr_write(REG_IMAGE_COLS, 9'(cw));
      csr_write(REG_IMAGE_ROWS, 9'(rw));
      csr_write(REG_KERNEL_ROWS, 9'(krw));
      csr_write(REG_KERNEL_COLS, 9'(kcw));
      csr_valid <= 0;
      cols = (cw == 0) ? 1 : (cw > 256) ? 256 : cw;
      rows = (rw == 0) ? 1 : (rw > 256) ? 256 : rw;
      for (int n = 0; n < frames * cols * rows + extra; n++) begin
         case (pix_mode)
            1:       p = 8'($urandom_range(255, 240));
            2:       p = $urandom_range(1) ? 8'hff : 8'h00;
            default: p = 8'($urandom_range(255));
         endcase
         put_word(CMD_PIXEL, 7'($urandom_range(127)), 8'($urandom_range(255)), p);
      end
   endtask

   initial begin
      int base;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      load_coefs(0);
      run_phase(6, 6, 3, 3, 1, 0, 2);
      run_phase(0, 0, 0, 0, 2, 0, 0);
      settle();
      csr_write(REG_SPARE, 9'h1ff);
      csr_valid <= 0;
      run_phase(511, 2, 1, 1, 1, 0, 0);
      run_phase(2, 256, 1, 1, 1, 0, 2);
      run_phase(10, 10, 15, 15, 1, 0, 0);
      run_phase(4, 4, 9, 9, 1, 0, 0);
      run_phase(7, 5, 2, 3, 1, 3, 0);
      settle();
      load_coefs(1);
      run_phase(8, 4, 2, 2, 1, 0, 1);
      settle();
      load_coefs(2);
      run_phase(8, 4, 2, 2, 1, 0, 1);
      settle();
      load_coefs(0);
      base = sent;
      for (int ph = 0; sent - base < 1400; ph++) begin
         if (ph % 4 == 3) begin
            settle();
            load_coefs(0);
         end
         calm = (ph == 2);
         if (ph == 5) begin
            hold_req <= 1;
            run_phase(20, 12, 2, 2, 1, 0, 0);
         end else begin
            run_phase($urandom_range(24, 1), $urandom_range(16, 1), $urandom_range(5, 1),
                      $urandom_range(5, 1), $urandom_range(2, 1), $urandom_range(1) ? 0 :
                      $urandom_range(30), 0);
         end
      end
      calm = 0;
      settle();
      repeat (20) @(posedge clock);
      if (errors == 0) $display("tb_conv2d_relu_maxpool: done, clean");
      else $display("tb_conv2d_relu_maxpool: done, errors");
      $finish;
   end

endmodule
